@@ design/dgi_pkg.sv @@
// shared constants, types and the declination table of the grid interpolator
`default_nettype none

package dgi_pkg;

  // payload widths
  localparam int LAT_W = 18;
  localparam int LON_W = 19;
  localparam int DEC_W = 21;

  // default number of fraction bits on the angle fields
  localparam int ANGLE_FRAC_BITS_DEF = 10;

  // table geometry
  localparam int LAT_ROWS = 13;
  localparam int LON_COLS = 37;
  localparam int ROW_W    = 4;
  localparam int COL_W    = 6;
  localparam int ROM_W    = 8;
  localparam int ROW_MAX  = LAT_ROWS - 2;
  localparam int COL_MAX  = LON_COLS - 2;

  // grid geometry in whole degrees
  localparam int GRID_DEG     = 10;
  localparam int LAT_SPAN_DEG = 90;
  localparam int LON_SPAN_DEG = 180;
  // grid rows between -90 and the first table row at -60
  localparam int ROW_OFS      = 3;

  typedef logic signed [ROM_W-1:0] rom_word_t;
  typedef rom_word_t [LAT_ROWS-1:0] rom_col_t;

  // control group for the divide unit, one load enable per stage
  typedef struct packed {
    logic ld_a;
    logic ld_b;
  } div_ctl_t;

  // declination in whole degrees, row 0 at -60, column 0 at -180
  localparam rom_word_t DEC_ROM [LAT_ROWS][LON_COLS] = '{
    '{ 8'sd46, 8'sd45, 8'sd44, 8'sd42, 8'sd41, 8'sd40, 8'sd38, 8'sd36, 8'sd33, 8'sd28,
       8'sd23, 8'sd16, 8'sd10, 8'sd4, -8'sd1, -8'sd5, -8'sd9, -8'sd14, -8'sd19, -8'sd26,
       -8'sd33, -8'sd40, -8'sd48, -8'sd55, -8'sd61, -8'sd66, -8'sd71, -8'sd74, -8'sd75,
       -8'sd72, -8'sd61, -8'sd25, 8'sd22, 8'sd40, 8'sd45, 8'sd47, 8'sd46 },
    '{ 8'sd30, 8'sd30, 8'sd30, 8'sd30, 8'sd29, 8'sd29, 8'sd29, 8'sd29, 8'sd27, 8'sd24,
       8'sd18, 8'sd11, 8'sd3, -8'sd3, -8'sd9, -8'sd12, -8'sd15, -8'sd17, -8'sd21, -8'sd26,
       -8'sd32, -8'sd39, -8'sd45, -8'sd51, -8'sd55, -8'sd57, -8'sd56, -8'sd53, -8'sd44,
       -8'sd31, -8'sd14, 8'sd0, 8'sd13, 8'sd21, 8'sd26, 8'sd29, 8'sd30 },
    '{ 8'sd21, 8'sd22, 8'sd22, 8'sd22, 8'sd22, 8'sd22, 8'sd22, 8'sd22, 8'sd21, 8'sd18,
       8'sd13, 8'sd5, -8'sd3, -8'sd11, -8'sd17, -8'sd20, -8'sd21, -8'sd22, -8'sd23, -8'sd25,
       -8'sd29, -8'sd35, -8'sd40, -8'sd44, -8'sd45, -8'sd44, -8'sd40, -8'sd32, -8'sd22,
       -8'sd12, -8'sd3, 8'sd3, 8'sd9, 8'sd14, 8'sd18, 8'sd20, 8'sd21 },
    '{ 8'sd16, 8'sd17, 8'sd17, 8'sd17, 8'sd17, 8'sd17, 8'sd16, 8'sd16, 8'sd16, 8'sd13,
       8'sd8, 8'sd0, -8'sd9, -8'sd16, -8'sd21, -8'sd24, -8'sd25, -8'sd25, -8'sd23, -8'sd20,
       -8'sd21, -8'sd24, -8'sd28, -8'sd31, -8'sd31, -8'sd29, -8'sd24, -8'sd17, -8'sd9,
       -8'sd3, 8'sd0, 8'sd4, 8'sd7, 8'sd10, 8'sd13, 8'sd15, 8'sd16 },
    '{ 8'sd12, 8'sd13, 8'sd13, 8'sd13, 8'sd13, 8'sd13, 8'sd12, 8'sd12, 8'sd11, 8'sd9,
       8'sd3, -8'sd4, -8'sd12, -8'sd19, -8'sd23, -8'sd24, -8'sd24, -8'sd22, -8'sd17, -8'sd12,
       -8'sd9, -8'sd10, -8'sd13, -8'sd17, -8'sd18, -8'sd16, -8'sd13, -8'sd8, -8'sd3,
       8'sd0, 8'sd1, 8'sd3, 8'sd6, 8'sd8, 8'sd10, 8'sd12, 8'sd12 },
    '{ 8'sd10, 8'sd10, 8'sd10, 8'sd10, 8'sd10, 8'sd10, 8'sd10, 8'sd9, 8'sd9, 8'sd6,
       8'sd0, -8'sd6, -8'sd14, -8'sd20, -8'sd22, -8'sd22, -8'sd19, -8'sd15, -8'sd10, -8'sd6,
       -8'sd2, -8'sd2, -8'sd4, -8'sd7, -8'sd8, -8'sd8, -8'sd7, -8'sd4, 8'sd0,
       8'sd1, 8'sd1, 8'sd2, 8'sd4, 8'sd6, 8'sd8, 8'sd10, 8'sd10 },
    '{ 8'sd9, 8'sd9, 8'sd9, 8'sd9, 8'sd9, 8'sd9, 8'sd8, 8'sd8, 8'sd7, 8'sd4,
       -8'sd1, -8'sd8, -8'sd15, -8'sd19, -8'sd20, -8'sd18, -8'sd14, -8'sd9, -8'sd5, -8'sd2,
       8'sd0, 8'sd1, 8'sd0, -8'sd2, -8'sd3, -8'sd4, -8'sd3, -8'sd2, 8'sd0,
       8'sd0, 8'sd0, 8'sd1, 8'sd3, 8'sd5, 8'sd7, 8'sd8, 8'sd9 },
    '{ 8'sd8, 8'sd8, 8'sd8, 8'sd9, 8'sd9, 8'sd9, 8'sd8, 8'sd8, 8'sd6, 8'sd2,
       -8'sd3, -8'sd9, -8'sd15, -8'sd18, -8'sd17, -8'sd14, -8'sd10, -8'sd6, -8'sd2, 8'sd0,
       8'sd1, 8'sd2, 8'sd2, 8'sd0, -8'sd1, -8'sd1, -8'sd2, -8'sd1, 8'sd0,
       8'sd0, 8'sd0, 8'sd0, 8'sd1, 8'sd3, 8'sd5, 8'sd7, 8'sd8 },
    '{ 8'sd8, 8'sd9, 8'sd9, 8'sd10, 8'sd10, 8'sd10, 8'sd10, 8'sd8, 8'sd5, 8'sd0,
       -8'sd5, -8'sd11, -8'sd15, -8'sd16, -8'sd15, -8'sd12, -8'sd8, -8'sd4, -8'sd1, 8'sd0,
       8'sd2, 8'sd3, 8'sd2, 8'sd1, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0,
       -8'sd1, -8'sd2, -8'sd2, -8'sd1, 8'sd0, 8'sd3, 8'sd6, 8'sd8 },
    '{ 8'sd6, 8'sd9, 8'sd10, 8'sd11, 8'sd12, 8'sd12, 8'sd11, 8'sd9, 8'sd5, 8'sd0,
       -8'sd7, -8'sd12, -8'sd15, -8'sd15, -8'sd13, -8'sd10, -8'sd7, -8'sd3, 8'sd0, 8'sd1,
       8'sd2, 8'sd3, 8'sd3, 8'sd3, 8'sd2, 8'sd1, 8'sd0, 8'sd0, -8'sd1,
       -8'sd3, -8'sd4, -8'sd5, -8'sd5, -8'sd2, 8'sd0, 8'sd3, 8'sd6 },
    '{ 8'sd5, 8'sd8, 8'sd11, 8'sd13, 8'sd15, 8'sd15, 8'sd14, 8'sd11, 8'sd5, -8'sd1,
       -8'sd9, -8'sd14, -8'sd17, -8'sd16, -8'sd14, -8'sd11, -8'sd7, -8'sd3, 8'sd0, 8'sd1,
       8'sd3, 8'sd4, 8'sd5, 8'sd5, 8'sd5, 8'sd4, 8'sd3, 8'sd1, -8'sd1,
       -8'sd4, -8'sd7, -8'sd8, -8'sd8, -8'sd6, -8'sd2, 8'sd1, 8'sd5 },
    '{ 8'sd4, 8'sd8, 8'sd12, 8'sd15, 8'sd17, 8'sd18, 8'sd16, 8'sd12, 8'sd5, -8'sd3,
       -8'sd12, -8'sd18, -8'sd20, -8'sd19, -8'sd16, -8'sd13, -8'sd8, -8'sd4, -8'sd1, 8'sd1,
       8'sd4, 8'sd6, 8'sd8, 8'sd9, 8'sd9, 8'sd9, 8'sd7, 8'sd3, -8'sd1,
       -8'sd6, -8'sd10, -8'sd12, -8'sd11, -8'sd9, -8'sd5, 8'sd0, 8'sd4 },
    '{ 8'sd3, 8'sd9, 8'sd14, 8'sd17, 8'sd20, 8'sd21, 8'sd19, 8'sd14, 8'sd4, -8'sd8,
       -8'sd19, -8'sd25, -8'sd26, -8'sd25, -8'sd21, -8'sd17, -8'sd12, -8'sd7, -8'sd2, 8'sd1,
       8'sd5, 8'sd9, 8'sd13, 8'sd15, 8'sd16, 8'sd16, 8'sd13, 8'sd7, 8'sd0,
       -8'sd7, -8'sd12, -8'sd15, -8'sd14, -8'sd11, -8'sd6, -8'sd1, 8'sd3 }
  };

  // one table column, all latitude rows of a longitude
  function automatic rom_col_t rom_column(input logic [COL_W-1:0] col);
    rom_col_t cv;
    for (int k = 0; k < LAT_ROWS; k++) begin
      cv[k] = DEC_ROM[k][col];
    end
    return cv;
  endfunction

endpackage

`default_nettype wire

@@ design/dgi_if.sv @@
// position and declination channel interfaces of the grid interpolator
`default_nettype none

interface dgi_in_if import dgi_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] latitude;
  logic signed [LON_W-1:0] longitude;

  modport source (output valid, latitude, longitude, input ready);
  modport sink   (input valid, latitude, longitude, output ready);
endinterface

interface dgi_out_if import dgi_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DEC_W-1:0] declination;
  logic                    out_of_range;
  logic                    saturated;

  modport source (output valid, declination, out_of_range, saturated, input ready);
  modport sink   (input valid, declination, out_of_range, saturated, output ready);
endinterface

`default_nettype wire

@@ design/dgi_div25.sv @@
// two stage floor division by 25 through a reciprocal multiply and a one step fix
`default_nettype none

module dgi_div25 import dgi_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  div_ctl_t                            ctl,
  input  logic signed [ANGLE_FRAC_BITS+20:0]  num,
  output logic signed [ANGLE_FRAC_BITS+17:0]  quo
);

  localparam int XW = ANGLE_FRAC_BITS + 21;
  localparam int SH = XW;
  localparam int MW = SH - 3;
  localparam int PW = XW + MW;
  localparam int QW = ANGLE_FRAC_BITS + 18;
  localparam int RW = QW + 6;

  localparam logic signed [MW-1:0] RECIP  = MW'(((64'd1 << SH) + 64'd24) / 64'd25);
  localparam logic signed [RW-1:0] DIV_K  = RW'(25);
  localparam logic signed [QW-1:0] Q_ONE  = QW'(1);

  logic signed [PW-1:0] prod_r;
  logic signed [XW-1:0] num_r;
  logic signed [QW-1:0] est;
  logic signed [RW-1:0] rem;
  logic signed [QW-1:0] q_nxt;
  logic signed [QW-1:0] q_r;

  // stage a: multiply by the reciprocal
  always_ff @(posedge clk) begin
    if (ctl.ld_a) begin
      prod_r <= PW'(num) * PW'(RECIP);
      num_r  <= num;
    end
  end

  // stage b: estimate is within one of the floor quotient, fix it by the remainder
  always_comb begin
    est   = prod_r[PW-1:SH];
    rem   = RW'(num_r) - RW'(est) * DIV_K;
    q_nxt = est;
    if (rem < 0) begin
      q_nxt = est - Q_ONE;
    end else if (rem >= DIV_K) begin
      q_nxt = est + Q_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_b) begin
      q_r <= q_nxt;
    end
  end

  assign quo = q_r;

endmodule

`default_nettype wire

@@ design/declination_grid_interpolator.sv @@
// magnetic declination from position by bilinear interpolation on a 10 degree grid
//
//   channel  dir  handshake        word
//   in_ch    in   valid / ready    latitude[17:0], longitude[18:0]
//   out_ch   out  valid / ready    declination[20:0], out_of_range, saturated
//
// nine register stages: grid index, offsets and column fetch, corner select and u*v,
// products, linear sum, scaled sum, two divide stages and the output register
// one word per cycle sustained while the output is ready
// each stage loads when it is empty or the stage after it loads, so bubbles close up
// under a stall and the input keeps taking words until every stage holds one
// rst_n is synchronous and clears the valid bits; the datapath is not reset
`default_nettype none

module declination_grid_interpolator import dgi_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  dgi_in_if.sink      in_ch,
  dgi_out_if.source   out_ch
);

  localparam int F    = ANGLE_FRAC_BITS;
  localparam int ONE  = 1 << F;
  localparam int D    = GRID_DEG * ONE;
  localparam int RND  = (GRID_DEG * GRID_DEG / 2) * ONE;
  localparam int NST  = 9;

  // widths
  localparam int EW   = (F + 10 > LON_W + 1) ? F + 10 : LON_W + 1;
  localparam int LOW  = F + 8;
  localparam int OOW  = F + 9;
  localparam int UW   = F + 5;
  localparam int VW   = F + 7;
  localparam int DFW  = ROM_W + 1;
  localparam int AW   = ROM_W + 2;
  localparam int UVW  = 2 * F + 12;
  localparam int M1W  = 2 * F + 22;
  localparam int M2W  = F + 14;
  localparam int M3W  = F + 16;
  localparam int LW   = F + 17;
  localparam int NW   = 2 * F + 23;
  localparam int XW   = F + 21;
  localparam int QW   = F + 18;

  localparam logic signed [EW-1:0] LAT_HI = EW'(LAT_SPAN_DEG * ONE);
  localparam logic signed [EW-1:0] LAT_LO = -LAT_HI;
  localparam logic signed [EW-1:0] LON_HI = EW'(LON_SPAN_DEG * ONE);
  localparam logic signed [EW-1:0] LON_LO = -LON_HI;
  localparam logic [16:0] DIV10_K   = 17'd205;
  localparam int          DIV10_SH  = 11;
  localparam logic [4:0]  ROW_OFS_C = 5'(ROW_OFS);
  localparam logic [4:0]  ROW_MAX_C = 5'(ROW_MAX);
  localparam logic [5:0]  COL_MAX_C = 6'(COL_MAX);
  localparam logic signed [QW-1:0] Q_MAX = QW'((1 << (DEC_W - 1)) - 1);
  localparam logic signed [QW-1:0] Q_MIN = -QW'(1 << (DEC_W - 1));

  // handshake and stage control
  logic [NST-1:0] vld_r;
  logic [NST-1:0] ld;
  logic [NST-2:0] oor_r;
  logic           in_acc;
  logic           out_acc;
  div_ctl_t       div_ctl;

  always_comb begin
    ld[NST-1] = !vld_r[NST-1] || out_ch.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      ld[k] = !vld_r[k] || ld[k+1];
    end
  end

  assign in_ch.ready  = ld[0] && rst_n;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_acc      = out_ch.valid && out_ch.ready;
  assign div_ctl.ld_a = ld[6];
  assign div_ctl.ld_b = ld[7];

  // valid bits and the out of range flag travel with the word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld[0]) begin
        vld_r[0] <= in_acc;
      end
      for (int k = 1; k < NST; k++) begin
        if (ld[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // stage 1: range check, offsets from the south west corner, grid index
  logic signed [EW-1:0] lat_x, lon_x, lat_off, lon_off;
  logic                 oor_nxt;
  logic [16:0]          lat_q, lon_q;
  logic [4:0]           row_raw;
  logic [5:0]           col_raw;
  logic [ROW_W-1:0]     row_nxt;
  logic [COL_W-1:0]     col_nxt;
  logic [LOW-1:0]       lat_off_r;
  logic [OOW-1:0]       lon_off_r;
  logic [ROW_W-1:0]     row_r1;
  logic [COL_W-1:0]     col_r1;

  always_comb begin
    lat_x   = EW'(in_ch.latitude);
    lon_x   = EW'(in_ch.longitude);
    oor_nxt = (lat_x < LAT_LO) || (lat_x > LAT_HI) || (lon_x < LON_LO) || (lon_x > LON_HI);
    lat_off = lat_x + LAT_HI;
    lon_off = lon_x + LON_HI;
    // whole degrees divided by ten through a reciprocal multiply
    lat_q   = 17'(lat_off[LOW-1:F]) * DIV10_K;
    lon_q   = 17'(lon_off[OOW-1:F]) * DIV10_K;
    row_raw = lat_q[DIV10_SH+4:DIV10_SH];
    col_raw = lon_q[DIV10_SH+5:DIV10_SH];
    if (row_raw < ROW_OFS_C) begin
      row_nxt = '0;
    end else if (row_raw - ROW_OFS_C > ROW_MAX_C) begin
      row_nxt = ROW_W'(ROW_MAX);
    end else begin
      row_nxt = ROW_W'(row_raw - ROW_OFS_C);
    end
    col_nxt = (col_raw > COL_MAX_C) ? COL_W'(COL_MAX) : col_raw;
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      lat_off_r <= lat_off[LOW-1:0];
      lon_off_r <= lon_off[OOW-1:0];
      row_r1    <= row_nxt;
      col_r1    <= col_nxt;
    end
  end

  // stage 2: position inside the cell, fetch two table columns
  logic [OOW-1:0]         u_full;
  logic [LOW:0]           v_full;
  logic signed [UW-1:0]   u_nxt, u_r2;
  logic signed [VW-1:0]   v_nxt, v_r2;
  logic [ROW_W-1:0]       row_r2;
  rom_col_t               cola_r, colb_r;

  always_comb begin
    u_full = lon_off_r - OOW'(col_r1) * OOW'(D);
    v_full = {1'b0, lat_off_r} - (LOW+1)'(row_r1 + ROW_W'(ROW_OFS)) * (LOW+1)'(D);
    u_nxt  = {1'b0, u_full[UW-2:0]};
    v_nxt  = v_full[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      u_r2     <= u_nxt;
      v_r2     <= v_nxt;
      row_r2   <= row_r1;
      cola_r   <= rom_column(col_r1);
      colb_r   <= rom_column(col_r1 + COL_W'(1));
    end
  end

  // stage 3: pick the four corners, differences and u*v
  rom_word_t               sw, se, nw, ne;
  logic [ROW_W-1:0]        row_up;
  logic signed [DFW-1:0]   ds_nxt, dn_nxt, ds_r3, dn_r3;
  logic signed [AW-1:0]    a_nxt, a_r3;
  logic signed [UVW-1:0]   uv_r3;
  logic signed [UW-1:0]    u_r3;
  logic signed [VW-1:0]    v_r3;
  rom_word_t               sw_r3;

  always_comb begin
    row_up = row_r2 + ROW_W'(1);
    sw     = cola_r[row_r2];
    nw     = cola_r[row_up];
    se     = colb_r[row_r2];
    ne     = colb_r[row_up];
    ds_nxt = DFW'(se) - DFW'(sw);
    dn_nxt = DFW'(nw) - DFW'(sw);
    a_nxt  = AW'(ne) - AW'(nw) - AW'(se) + AW'(sw);
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      ds_r3    <= ds_nxt;
      dn_r3    <= dn_nxt;
      a_r3     <= a_nxt;
      sw_r3    <= sw;
      u_r3     <= u_r2;
      v_r3     <= v_r2;
      uv_r3    <= UVW'(u_r2) * UVW'(v_r2);
    end
  end

  // stage 4: the three products
  logic signed [M1W-1:0] m1_r4;
  logic signed [M2W-1:0] m2_r4;
  logic signed [M3W-1:0] m3_r4;
  rom_word_t             sw_r4;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      m1_r4    <= M1W'(uv_r3) * M1W'(a_r3);
      m2_r4    <= M2W'(u_r3) * M2W'(ds_r3);
      m3_r4    <= M3W'(v_r3) * M3W'(dn_r3);
      sw_r4    <= sw_r3;
    end
  end

  // stage 5: linear part sw*D + u*ds + v*dn
  logic signed [LW-1:0]  lin_r5;
  logic signed [M1W-1:0] m1_r5;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      lin_r5   <= LW'(sw_r4) * LW'(D) + LW'(m2_r4) + LW'(m3_r4);
      m1_r5    <= m1_r4;
    end
  end

  // stage 6: full sum with rounding, drop the power of two part of the divisor
  logic signed [NW-1:0] n_nxt;
  logic signed [XW-1:0] x_r6;

  assign n_nxt = NW'(lin_r5) * NW'(D) + NW'(m1_r5) + NW'(RND);

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      x_r6     <= n_nxt[NW-1:F+2];
    end
  end

  // stages 7 and 8: floor division by 25
  logic signed [QW-1:0] quo;

  dgi_div25 #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_div (
    .clk (clk),
    .ctl (div_ctl),
    .num (x_r6),
    .quo (quo)
  );

  // out of range flag shifts along with the valid bits
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      oor_r[0] <= oor_nxt;
    end
    for (int k = 1; k < NST - 1; k++) begin
      if (ld[k]) begin
        oor_r[k] <= oor_r[k-1];
      end
    end
  end

  // output register: saturate, or zero for an invalid position
  logic signed [DEC_W-1:0] dec_nxt, dec_r;
  logic                    sat_nxt, sat_r, oor_out_r;

  always_comb begin
    if (oor_r[7]) begin
      dec_nxt = '0;
      sat_nxt = 1'b0;
    end else if (quo > Q_MAX) begin
      dec_nxt = Q_MAX[DEC_W-1:0];
      sat_nxt = 1'b1;
    end else if (quo < Q_MIN) begin
      dec_nxt = Q_MIN[DEC_W-1:0];
      sat_nxt = 1'b1;
    end else begin
      dec_nxt = quo[DEC_W-1:0];
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[8]) begin
      dec_r     <= dec_nxt;
      sat_r     <= sat_nxt;
      oor_out_r <= oor_r[7];
    end
  end

  assign out_ch.valid        = vld_r[NST-1];
  assign out_ch.declination  = dec_r;
  assign out_ch.out_of_range = oor_out_r;
  assign out_ch.saturated    = sat_r;

  // words in flight change only by accepts and deliveries
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> $countones(vld_r) ==
      $countones($past(vld_r)) + int'($past(in_acc)) - int'($past(out_acc)))
    else $error("pipeline word count out of step with handshakes");

  // input only backs off when every stage holds a word
  a_full: assert property (@(posedge clk)
    rst_n && !in_ch.ready |-> &vld_r)
    else $error("input stalled with a free stage");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  // a clipped result sits at a range limit and never on an invalid position
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.saturated |->
      !out_ch.out_of_range &&
      (out_ch.declination == Q_MAX[DEC_W-1:0] || out_ch.declination == Q_MIN[DEC_W-1:0]))
    else $error("saturated flag without a limit value");

endmodule

`default_nettype wire
